// ===== design/wer_pkg.sv =====
// package with constants and types for the windowed event rate meter
`timescale 1ns / 1ps
`default_nettype none

package wer_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned FRAC_BITS  = 8;

  localparam int unsigned RATE_W     = 24;
  localparam int unsigned TS_W       = 32;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned RATE_SCALE = 1000 << FRAC_BITS;
  localparam int unsigned SCALE_W    = $clog2(RATE_SCALE + 1);
  localparam int unsigned NUM_W      = COUNT_BITS + SCALE_W;
  localparam int unsigned SM_W       = RATE_W + 4;
  localparam int unsigned QUO_W      = (NUM_W > SM_W) ? NUM_W : SM_W;
  localparam int unsigned STEP_W     = $clog2(QUO_W + 1);
  localparam int unsigned SM_DIVISOR = 10;

  localparam logic [RATE_W-1:0]     RATE_MAX     = '1;
  localparam logic [RATE_W-1:0]     DEFAULT_RATE = RATE_W'(60 << FRAC_BITS);
  localparam logic [WIN_W-1:0]      WINDOW_RESET = WIN_W'(1000);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIXED_MODE = 2'd0,
    CFG_FIXED_RATE = 2'd1,
    CFG_WINDOW_MS  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ACT_FRAME   = 1'b0,
    ACT_RESTART = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RAW,
    ST_LOAD_SM,
    ST_DIV_SM,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== design/windowed_event_rate_meter_core.sv =====
// windowed event rate meter: window tracking, shared restoring divider and sequencer
//
// input channel: action_i (0 frame event, 1 window restart) and timestamp_ms_i,
// taken when in_valid_i is high and in_stall_o is low. every input transaction
// produces exactly one output transaction with reported_rate_o, best_rate_o,
// worst_rate_o and window_closed_o, handed over when out_valid_o is high and
// out_stall_i is low.
// restarts, fixed-mode events and frame events that do not close the window
// are resolved in the accept cycle; the result is registered and shows in the next cycle.
// a frame event that closes the window runs one shared subtract/compare unit
// as a restoring divider: QUO_W steps (34) for count*1000*256/elapsed, a load
// state, SM_W steps (28) for the divide by ten of the smoothing, and a finishing
// state that waits until the output register is free.
// one transaction is in work at a time; in_stall_o stays high while the
// divider runs and while a finished result is held by out_stall_i.
// configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at the
// next edge; index 3 is ignored.
// reset (rst_ni low, asynchronous) returns the control and state registers to their
// start values: 60 fps fixed rate and previous rate, 1000 ms window, best rate zero,
// worst and smoothed rate all ones.
`timescale 1ns / 1ps
`default_nettype none

module windowed_event_rate_meter_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,

  input  wire logic                             cfg_we_i,
  input  wire logic [wer_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [wer_pkg::CFG_DATA_W-1:0]   cfg_data_i,

  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             action_i,
  input  wire logic [wer_pkg::TS_W-1:0]         timestamp_ms_i,

  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [wer_pkg::RATE_W-1:0]            reported_rate_o,
  output logic [wer_pkg::RATE_W-1:0]            best_rate_o,
  output logic [wer_pkg::RATE_W-1:0]            worst_rate_o,
  output logic                                  window_closed_o
);

  wer_pkg::state_e state_q, state_d;

  logic                             fixed_mode_q, fixed_mode_d;
  logic [wer_pkg::RATE_W-1:0]       fixed_rate_q, fixed_rate_d;
  logic [wer_pkg::WIN_W-1:0]        window_ms_q, window_ms_d;

  logic [wer_pkg::TS_W-1:0]         window_start_q, window_start_d;
  logic [wer_pkg::COUNT_BITS-1:0]   frame_count_q, frame_count_d;
  logic [wer_pkg::RATE_W-1:0]       previous_raw_q, previous_raw_d;
  logic [wer_pkg::RATE_W-1:0]       smoothed_q, smoothed_d;
  logic [wer_pkg::RATE_W-1:0]       highest_q, highest_d;
  logic [wer_pkg::RATE_W-1:0]       lowest_q, lowest_d;

  logic [wer_pkg::STEP_W-1:0]       step_q, step_d;
  logic [wer_pkg::QUO_W-1:0]        quo_q, quo_d;
  logic [wer_pkg::TS_W-1:0]         rem_q, rem_d;
  logic [wer_pkg::TS_W-1:0]         div_q, div_d;
  logic [wer_pkg::TS_W-1:0]         ts_q, ts_d;
  logic [wer_pkg::RATE_W-1:0]       raw_q, raw_d;

  logic                             out_valid_q, out_valid_d;
  logic [wer_pkg::RATE_W-1:0]       out_rate_q, out_rate_d;
  logic [wer_pkg::RATE_W-1:0]       out_best_q, out_best_d;
  logic [wer_pkg::RATE_W-1:0]       out_worst_q, out_worst_d;
  logic                             out_closed_q, out_closed_d;

  logic                             accept;
  logic                             out_free;
  logic [wer_pkg::COUNT_BITS-1:0]   count_inc;
  logic [wer_pkg::TS_W-1:0]         elapsed;
  logic                             closes;
  logic [wer_pkg::NUM_W-1:0]        num;
  logic [wer_pkg::TS_W:0]           shifted;
  logic [wer_pkg::TS_W:0]           diff;
  logic                             ge;
  logic [wer_pkg::RATE_W-1:0]       raw_sat;
  logic [wer_pkg::SM_W-1:0]         sm_num;
  logic [wer_pkg::RATE_W-1:0]       sm_new;
  logic [wer_pkg::RATE_W-1:0]       hi_new;
  logic [wer_pkg::RATE_W-1:0]       lo_new;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != wer_pkg::ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign count_inc = (frame_count_q < wer_pkg::COUNT_MAX) ?
                     frame_count_q + wer_pkg::COUNT_BITS'(1) : frame_count_q;
  assign elapsed   = timestamp_ms_i - window_start_q;
  assign closes    = elapsed > wer_pkg::TS_W'(window_ms_q);
  assign num       = wer_pkg::NUM_W'(count_inc) * wer_pkg::NUM_W'(wer_pkg::RATE_SCALE);

  // shared subtract/compare step of the restoring divider
  assign shifted = {rem_q, quo_q[wer_pkg::QUO_W-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = shifted >= {1'b0, div_q};

  assign raw_sat = (quo_q > wer_pkg::QUO_W'(wer_pkg::RATE_MAX)) ?
                   wer_pkg::RATE_MAX : quo_q[wer_pkg::RATE_W-1:0];
  assign sm_num  = wer_pkg::SM_W'({previous_raw_q, 1'b0}) + wer_pkg::SM_W'({raw_sat, 3'b000});
  assign sm_new  = quo_q[wer_pkg::RATE_W-1:0];
  assign hi_new  = (sm_new > highest_q) ? sm_new : highest_q;
  assign lo_new  = (sm_new < lowest_q) ? sm_new : lowest_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wer_pkg::ST_IDLE: begin
        if (accept && (action_i != wer_pkg::ACT_RESTART) && !fixed_mode_q && closes) begin
          state_d = wer_pkg::ST_DIV_RAW;
        end
      end
      wer_pkg::ST_DIV_RAW: begin
        if (step_q == wer_pkg::STEP_W'(1)) begin
          state_d = wer_pkg::ST_LOAD_SM;
        end
      end
      wer_pkg::ST_LOAD_SM: begin
        state_d = wer_pkg::ST_DIV_SM;
      end
      wer_pkg::ST_DIV_SM: begin
        if (step_q == wer_pkg::STEP_W'(1)) begin
          state_d = wer_pkg::ST_DONE;
        end
      end
      wer_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = wer_pkg::ST_IDLE;
        end
      end
      default: state_d = wer_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    fixed_mode_d   = fixed_mode_q;
    fixed_rate_d   = fixed_rate_q;
    window_ms_d    = window_ms_q;
    window_start_d = window_start_q;
    frame_count_d  = frame_count_q;
    previous_raw_d = previous_raw_q;
    smoothed_d     = smoothed_q;
    highest_d      = highest_q;
    lowest_d       = lowest_q;
    step_d         = step_q;
    quo_d          = quo_q;
    rem_d          = rem_q;
    div_d          = div_q;
    ts_d           = ts_q;
    raw_d          = raw_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_rate_d     = out_rate_q;
    out_best_d     = out_best_q;
    out_worst_d    = out_worst_q;
    out_closed_d   = out_closed_q;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        wer_pkg::CFG_FIXED_MODE: fixed_mode_d = cfg_data_i[0];
        wer_pkg::CFG_FIXED_RATE: fixed_rate_d = cfg_data_i[wer_pkg::RATE_W-1:0];
        wer_pkg::CFG_WINDOW_MS:  window_ms_d  = cfg_data_i[wer_pkg::WIN_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      wer_pkg::ST_IDLE: begin
        if (accept) begin
          if (action_i == wer_pkg::ACT_RESTART) begin
            window_start_d = timestamp_ms_i;
            frame_count_d  = '0;
          end else if (!fixed_mode_q) begin
            frame_count_d = count_inc;
          end
          if ((action_i != wer_pkg::ACT_RESTART) && !fixed_mode_q && closes) begin
            ts_d   = timestamp_ms_i;
            quo_d  = wer_pkg::QUO_W'(num);
            rem_d  = '0;
            div_d  = elapsed;
            step_d = wer_pkg::STEP_W'(wer_pkg::QUO_W);
          end else begin
            out_valid_d  = 1'b1;
            out_rate_d   = fixed_mode_q ? fixed_rate_q : smoothed_q;
            out_best_d   = highest_q;
            out_worst_d  = lowest_q;
            out_closed_d = 1'b0;
          end
        end
      end
      wer_pkg::ST_DIV_RAW,
      wer_pkg::ST_DIV_SM: begin
        rem_d  = ge ? diff[wer_pkg::TS_W-1:0] : shifted[wer_pkg::TS_W-1:0];
        quo_d  = {quo_q[wer_pkg::QUO_W-2:0], ge};
        step_d = step_q - wer_pkg::STEP_W'(1);
      end
      wer_pkg::ST_LOAD_SM: begin
        raw_d  = raw_sat;
        quo_d  = wer_pkg::QUO_W'(sm_num) << (wer_pkg::QUO_W - wer_pkg::SM_W);
        rem_d  = '0;
        div_d  = wer_pkg::TS_W'(wer_pkg::SM_DIVISOR);
        step_d = wer_pkg::STEP_W'(wer_pkg::SM_W);
      end
      wer_pkg::ST_DONE: begin
        if (out_free) begin
          smoothed_d     = sm_new;
          highest_d      = hi_new;
          lowest_d       = lo_new;
          previous_raw_d = raw_q;
          window_start_d = ts_q;
          frame_count_d  = '0;
          out_valid_d    = 1'b1;
          out_rate_d     = fixed_mode_q ? fixed_rate_q : sm_new;
          out_best_d     = hi_new;
          out_worst_d    = lo_new;
          out_closed_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= wer_pkg::ST_IDLE;
      fixed_mode_q   <= 1'b0;
      fixed_rate_q   <= wer_pkg::DEFAULT_RATE;
      window_ms_q    <= wer_pkg::WINDOW_RESET;
      window_start_q <= '0;
      frame_count_q  <= '0;
      previous_raw_q <= wer_pkg::DEFAULT_RATE;
      smoothed_q     <= wer_pkg::RATE_MAX;
      highest_q      <= '0;
      lowest_q       <= wer_pkg::RATE_MAX;
      step_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      fixed_mode_q   <= fixed_mode_d;
      fixed_rate_q   <= fixed_rate_d;
      window_ms_q    <= window_ms_d;
      window_start_q <= window_start_d;
      frame_count_q  <= frame_count_d;
      previous_raw_q <= previous_raw_d;
      smoothed_q     <= smoothed_d;
      highest_q      <= highest_d;
      lowest_q       <= lowest_d;
      step_q         <= step_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // divider and output payload
  always_ff @(posedge clk_i) begin
    quo_q        <= quo_d;
    rem_q        <= rem_d;
    div_q        <= div_d;
    ts_q         <= ts_d;
    raw_q        <= raw_d;
    out_rate_q   <= out_rate_d;
    out_best_q   <= out_best_d;
    out_worst_q  <= out_worst_d;
    out_closed_q <= out_closed_d;
  end

  assign out_valid_o     = out_valid_q;
  assign reported_rate_o = out_rate_q;
  assign best_rate_o     = out_best_q;
  assign worst_rate_o    = out_worst_q;
  assign window_closed_o = out_closed_q;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for the windowed event rate meter core
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned TAIL_CYCLES = 80;
  localparam int unsigned PRINT_CAP   = 100;
  localparam logic [wer_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [63:0] MS_Q_SCALE = 64'd1000 << wer_pkg::FRAC_BITS;

  typedef struct {
    wer_pkg::action_e         act;
    logic [wer_pkg::TS_W-1:0] ts;
  } meter_txn_t;

  typedef struct {
    logic [wer_pkg::RATE_W-1:0] rate;
    logic [wer_pkg::RATE_W-1:0] best;
    logic [wer_pkg::RATE_W-1:0] worst;
    logic                       closed;
  } rate_result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [wer_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [wer_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic                           action_i = 1'b0;
  logic [wer_pkg::TS_W-1:0]       timestamp_ms_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [wer_pkg::RATE_W-1:0]     reported_rate_o;
  logic [wer_pkg::RATE_W-1:0]     best_rate_o;
  logic [wer_pkg::RATE_W-1:0]     worst_rate_o;
  logic                           window_closed_o;

  windowed_event_rate_meter_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .timestamp_ms_i  (timestamp_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .reported_rate_o (reported_rate_o),
    .best_rate_o     (best_rate_o),
    .worst_rate_o    (worst_rate_o),
    .window_closed_o (window_closed_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // predicted meter state and register copies
  logic                           mode_fixed    = 1'b0;
  logic [wer_pkg::RATE_W-1:0]     rate_fixed    = wer_pkg::DEFAULT_RATE;
  logic [wer_pkg::WIN_W-1:0]      window_len    = wer_pkg::WINDOW_RESET;
  logic [wer_pkg::TS_W-1:0]       window_origin = '0;
  logic [wer_pkg::COUNT_BITS-1:0] frames_seen   = '0;
  logic [wer_pkg::RATE_W-1:0]     last_raw      = wer_pkg::DEFAULT_RATE;
  logic [wer_pkg::RATE_W-1:0]     smooth_rate   = wer_pkg::RATE_MAX;
  logic [wer_pkg::RATE_W-1:0]     peak_rate     = '0;
  logic [wer_pkg::RATE_W-1:0]     floor_rate    = wer_pkg::RATE_MAX;

  meter_txn_t   pending_q[$];
  rate_result_t rate_expect_q[$];
  rate_result_t want;
  meter_txn_t   nxt;
  int unsigned  sent_count = 0;
  int unsigned  taken_count = 0;
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  gap_left = 0;
  int unsigned  stall_left = 0;
  bit           quiet_in = 1'b0;
  bit           quiet_out = 1'b0;

  function automatic rate_result_t meter_step(input wer_pkg::action_e act,
                                              input logic [wer_pkg::TS_W-1:0] ts);
    rate_result_t             res;
    logic [wer_pkg::TS_W-1:0] span_ms;
    logic [63:0]              quot;
    logic [63:0]              blend;
    res.closed = 1'b0;
    if (act == wer_pkg::ACT_RESTART) begin
      window_origin = ts;
      frames_seen = '0;
    end else if (!mode_fixed) begin
      if (frames_seen != wer_pkg::COUNT_MAX) frames_seen = frames_seen + 1'b1;
      span_ms = ts - window_origin;
      if (span_ms > wer_pkg::TS_W'(window_len)) begin
        quot = (64'(frames_seen) * MS_Q_SCALE) / 64'(span_ms);
        if (quot > 64'(wer_pkg::RATE_MAX)) quot = 64'(wer_pkg::RATE_MAX);
        blend = (64'(last_raw) * 2 + quot * 8) / 10;
        smooth_rate = blend[wer_pkg::RATE_W-1:0];
        if (smooth_rate > peak_rate) peak_rate = smooth_rate;
        if (smooth_rate < floor_rate) floor_rate = smooth_rate;
        last_raw = quot[wer_pkg::RATE_W-1:0];
        window_origin = ts;
        frames_seen = '0;
        res.closed = 1'b1;
      end
    end
    res.rate = mode_fixed ? rate_fixed : smooth_rate;
    res.best = peak_rate;
    res.worst = floor_rate;
    return res;
  endfunction

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic push_txn(input wer_pkg::action_e act, input logic [wer_pkg::TS_W-1:0] ts);
    meter_txn_t t;
    t.act = act;
    t.ts = ts;
    pending_q.push_back(t);
  endtask

  task automatic set_reg(input logic [wer_pkg::CFG_IDX_W-1:0] idx,
                         input logic [wer_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    case (idx)
      wer_pkg::CFG_FIXED_MODE: mode_fixed = data[0];
      wer_pkg::CFG_FIXED_RATE: rate_fixed = data[wer_pkg::RATE_W-1:0];
      wer_pkg::CFG_WINDOW_MS:  window_len = data[wer_pkg::WIN_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sender holds off until every transaction has come back
  task automatic drain();
    while (pending_q.size() != 0 || sent_count != taken_count || rate_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned n);
    logic [wer_pkg::TS_W-1:0] now;
    logic [wer_pkg::TS_W-1:0] step;
    logic [wer_pkg::TS_W-1:0] ts;
    int unsigned              span;
    int unsigned              r;
    wer_pkg::action_e         act;
    now = $urandom;
    span = int'(window_len) / 4 + 2;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        push_txn(wer_pkg::ACT_RESTART, now);
      end else if (r < 10) begin
        act = $urandom_range(0, 1) ? wer_pkg::ACT_RESTART : wer_pkg::ACT_FRAME;
        ts = $urandom;
        if (act == wer_pkg::ACT_RESTART) now = ts;
        push_txn(act, ts);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 25) step = '0;
        else if (r < 85) step = $urandom_range(1, span);
        else if (r < 97) step = $urandom_range(span, 2 * int'(window_len) + 2);
        else step = $urandom;
        now = now + step;
        push_txn(wer_pkg::ACT_FRAME, now);
      end
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        rate_expect_q.push_back(meter_step(action_i ? wer_pkg::ACT_RESTART : wer_pkg::ACT_FRAME,
                                           timestamp_ms_i));
        taken_count++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left--;
        end else if (pending_q.size() != 0) begin
          nxt = pending_q.pop_front();
          in_valid_i <= 1'b1;
          action_i <= (nxt.act == wer_pkg::ACT_RESTART);
          timestamp_ms_i <= nxt.ts;
          sent_count++;
          gap_left = pick_gap(quiet_in);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (rate_expect_q.size() == 0) begin
          report_error("result transaction with no prediction pending");
        end else begin
          want = rate_expect_q.pop_front();
          if (reported_rate_o !== want.rate)
            report_error($sformatf("reported_rate %h, predicted %h", reported_rate_o, want.rate));
          if (best_rate_o !== want.best)
            report_error($sformatf("best_rate %h, predicted %h", best_rate_o, want.best));
          if (worst_rate_o !== want.worst)
            report_error($sformatf("worst_rate %h, predicted %h", worst_rate_o, want.worst));
          if (window_closed_o !== want.closed)
            report_error($sformatf("window_closed %b, predicted %b", window_closed_o,
                                   want.closed));
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = pick_gap(quiet_out);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    logic [wer_pkg::TS_W-1:0] base;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: closing edge, wrap, huge elapsed
    push_txn(wer_pkg::ACT_FRAME, 32'h0000_0000);
    push_txn(wer_pkg::ACT_FRAME, 32'd1000);
    push_txn(wer_pkg::ACT_FRAME, 32'd1001);
    push_txn(wer_pkg::ACT_RESTART, 32'hFFFF_FFF0);
    push_txn(wer_pkg::ACT_FRAME, 32'h0000_0010);
    push_txn(wer_pkg::ACT_FRAME, 32'h0000_0400);
    push_txn(wer_pkg::ACT_FRAME, 32'hFFFF_FFFF);
    push_txn(wer_pkg::ACT_RESTART, 32'h0000_0000);
    push_txn(wer_pkg::ACT_FRAME, 32'h8000_0000);
    push_txn(wer_pkg::ACT_RESTART, 32'hAAAA_5555);
    push_txn(wer_pkg::ACT_FRAME, 32'h5555_AAAA);
    drain();

    // fixed mode, then back to the measured rate
    set_reg(wer_pkg::CFG_FIXED_MODE, 24'hFFFFFF);
    set_reg(wer_pkg::CFG_FIXED_RATE, 24'h000000);
    push_txn(wer_pkg::ACT_FRAME, 32'd123);
    push_txn(wer_pkg::ACT_RESTART, 32'd5000);
    push_txn(wer_pkg::ACT_FRAME, 32'd9000);
    drain();
    set_reg(wer_pkg::CFG_FIXED_RATE, 24'hFFFFFF);
    push_txn(wer_pkg::ACT_FRAME, 32'd9500);
    drain();
    set_reg(wer_pkg::CFG_FIXED_MODE, 24'hFFFFFE);
    push_txn(wer_pkg::ACT_FRAME, 32'd5500);
    push_txn(wer_pkg::ACT_FRAME, 32'd6001);
    drain();

    // zero-length window
    set_reg(wer_pkg::CFG_WINDOW_MS, 24'h000000);
    push_txn(wer_pkg::ACT_RESTART, 32'd100);
    push_txn(wer_pkg::ACT_FRAME, 32'd100);
    push_txn(wer_pkg::ACT_FRAME, 32'd101);
    drain();

    // raw rate saturation
    quiet_in = 1'b1;
    quiet_out = 1'b1;
    set_reg(wer_pkg::CFG_WINDOW_MS, 24'd1);
    base = 32'h1234_0000;
    push_txn(wer_pkg::ACT_RESTART, base);
    repeat (140) push_txn(wer_pkg::ACT_FRAME, base);
    push_txn(wer_pkg::ACT_FRAME, base + 2);
    drain();

    for (int p = 0; p < 8; p++) begin
      quiet_in = (p == 1);
      quiet_out = (p == 1) || (p == 6);
      case (p)
        0: set_reg(wer_pkg::CFG_WINDOW_MS, 24'(wer_pkg::WINDOW_RESET));
        1: set_reg(wer_pkg::CFG_WINDOW_MS, 24'd1);
        2: begin
          set_reg(wer_pkg::CFG_WINDOW_MS, 24'h00FFFF);
          set_reg(wer_pkg::CFG_FIXED_RATE, 24'($urandom));
        end
        3: begin
          set_reg(wer_pkg::CFG_FIXED_MODE, 24'd1);
          set_reg(wer_pkg::CFG_FIXED_RATE, 24'($urandom));
          set_reg(wer_pkg::CFG_WINDOW_MS, 24'd10);
        end
        4: begin
          set_reg(wer_pkg::CFG_FIXED_MODE, 24'd0);
          set_reg(wer_pkg::CFG_WINDOW_MS, 24'($urandom_range(2, 200)));
          set_reg(CFG_SPARE, 24'($urandom));
        end
        5: set_reg(wer_pkg::CFG_WINDOW_MS, 24'd0);
        6: set_reg(wer_pkg::CFG_WINDOW_MS, 24'($urandom_range(1, 65535)));
        default: begin
          set_reg(wer_pkg::CFG_WINDOW_MS, 24'd5);
          set_reg(wer_pkg::CFG_FIXED_RATE, 24'd0);
        end
      endcase
      random_phase(160);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/wer_pkg.sv
design/windowed_event_rate_meter_core.sv
dv/testbench.sv
